// ===== rtl/sds_pkg.sv =====
// Shared types and constants for the stencil diffusion step.
// No dependencies; imported by the top level, sds_cell and sds_window.
`default_nettype none

package sds_pkg;

    localparam int GW_W      = 11;   // grid_width register
    localparam int H_W       = 13;   // grid_height register, also dimension compares
    localparam int ROW_W     = 12;   // row counter and cell_row
    localparam int GAIN_W    = 18;   // step_gain register
    localparam int IDX_W     = 4;    // coef_index field
    localparam int CFG_IDX_W = 2;
    localparam int COEF_FRAC = 8;
    localparam int GAIN_FRAC = 17;

    localparam logic [H_W-1:0]  MIN_DIM      = 13'd3;
    localparam logic [H_W-1:0]  MAX_HEIGHT   = 13'd4096;
    localparam logic [GW_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [H_W-1:0]  HEIGHT_RESET = 13'd1024;

    localparam logic ACT_COEF   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_STEP_GAIN   = 2'd2
    } cfg_reg_t;

    // controls broadcast along the window cells
    typedef struct packed {
        logic             shift;     // move window one column left, take new column
        logic             load;      // coefficient write
        logic             mul;       // form products for the current window
        logic             step;      // pipeline advance for the sum registers
        logic [IDX_W-1:0] load_idx;
    } cell_ctrl_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             last;
    } cell_meta_t;

endpackage

`default_nettype wire

// ===== rtl/stencil_diffusion_step.sv =====
// Top level: raster counters, line memories, window chain and the update pipeline.
// Depends on sds_pkg, sds_ram and sds_window.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tuser: action; tdata: coef_index, value
//  m_*     | out | m_tvalid/m_tready | tdata: new_value, laplacian, cell_row, cell_col;
//          |     |                   | tlast: last_cell
//  cfg_*   | in  | cfg_we            | cfg_index, cfg_data (no read-back)
//
// One item per cycle unless a result waits on m_tready; m_tvalid follows its sample down v_reg.
// All stages move together and freeze while a result waits on m_tready.
// Line memories (MASK_SIZE-1 rows of MAX_WIDTH) are not cleared; no start-up pass.
// Reset clears counters, valid flags, window samples, coefficients and step gain; width and height go to 1024.
`default_nettype none

module stencil_diffusion_step #(
    parameter int MASK_SIZE   = 3,
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 18,
    localparam int COL_W       = $clog2(MAX_WIDTH),
    localparam int IN_TDATA_W  = ((sds_pkg::IDX_W + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + sds_pkg::ROW_W + COL_W + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sds_pkg::GAIN_W-1:0]         cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_TDATA_W-1:0]              s_tdata,   // coef_index, value
    input  logic                               s_tuser,   // action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [OUT_TDATA_W-1:0]             m_tdata,   // new_value, laplacian,
                                                          // cell_row, cell_col
    output logic                               m_tlast
);

    import sds_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int LINES  = MASK_SIZE - 1;
    localparam int HALF   = MASK_SIZE / 2;
    localparam int RM_W   = $clog2(LINES);
    localparam int ACC_W  = 2 * SB + 2 * $clog2(MASK_SIZE);
    localparam int GP_W   = SB + GAIN_W + 1;
    localparam int NV_W   = SB + 20;

    localparam logic signed [ACC_W:0] LAP_HALF = (ACC_W + 1)'(2 ** (COEF_FRAC - 1));
    localparam logic signed [ACC_W:0] LAP_MAX  = {{(ACC_W + 2 - SB){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [ACC_W:0] LAP_MIN  = {{(ACC_W + 2 - SB){1'b1}}, {(SB - 1){1'b0}}};
    localparam logic signed [NV_W-1:0] NV_HALF = NV_W'(2 ** (GAIN_FRAC - 1));
    localparam logic signed [NV_W-1:0] NV_MAX  = {{(NV_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [NV_W-1:0] NV_MIN  = {{(NV_W - SB + 1){1'b1}}, {(SB - 1){1'b0}}};
    localparam logic signed [SB-1:0]   S_MAX   = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0]   S_MIN   = {1'b1, {(SB - 1){1'b0}}};

    // configuration and raster state
    logic [GW_W-1:0]   grid_width_reg;
    logic [H_W-1:0]    grid_height_reg;
    logic [GAIN_W-1:0] step_gain_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [RM_W-1:0]   rmod_reg, rmod_next;

    // handshake
    logic adv;
    logic acc_in;
    logic acc_smp;
    logic mvalid_reg;

    // input unpacking
    logic [IDX_W-1:0]     in_idx;
    logic signed [SB-1:0] in_value;

    // current-sample position
    logic [H_W-1:0]   w13, h13, r_t, r_t2, c_t;
    logic             wrap_c, wrap_n;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r0;
    logic [RM_W-1:0]  m_t, m_t2, m0;
    logic             emit0, last0;
    logic [ROW_W-1:0] crow0;
    logic [COL_W-1:0] ccol0;

    // line memories
    logic [LINES-1:0] ram_we;
    logic [SB-1:0]    ram_rd [LINES];

    // pipeline
    logic [7:1]           v_reg;
    logic                 smp_reg  [1:2];
    logic [IDX_W-1:0]     idx_reg  [1:2];
    logic signed [SB-1:0] val_reg  [1:2];
    logic                 emit_reg [1:2];
    logic [RM_W-1:0]      rm1_reg;
    cell_meta_t           meta_reg [1:7];
    logic [COL_W-1:0]     colp_reg [1:7];
    logic signed [SB-1:0] ctr_reg  [3:7];
    logic signed [SB-1:0] lap6_reg, lap7_reg;
    logic signed [GP_W-1:0] gp_reg;

    // window
    cell_ctrl_t               wctrl;
    logic signed [SB-1:0]     col_in [MASK_SIZE];
    logic signed [SB-1:0]     center;
    logic signed [ACC_W-1:0]  acc;
    logic [RM_W:0]            slot_sum [LINES];

    // arithmetic
    logic signed [ACC_W:0]   acc_rnd;
    logic signed [SB-1:0]    lap_sat;
    logic signed [NV_W-1:0]  nv_sum, nv_sh;
    logic signed [SB-1:0]    nv_sat;

    // output register
    logic signed [SB-1:0] out_nv_reg, out_lap_reg;
    cell_meta_t           out_meta_reg;
    logic [COL_W-1:0]     out_col_reg;

    assign adv      = !mvalid_reg || m_tready;
    assign s_tready = adv;
    assign acc_in   = s_tvalid && adv;
    assign acc_smp  = acc_in && (s_tuser == ACT_SAMPLE);
    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_value = $signed(s_tdata[IDX_W+SB-1:IDX_W]);

    // raster position: wrap a stale counter first, then step past this sample
    always_comb
    begin
        w13 = H_W'(grid_width_reg);
        if (w13 < MIN_DIM)
        begin
            w13 = MIN_DIM;
        end
        else if (w13 > H_W'(MAX_WIDTH))
        begin
            w13 = H_W'(MAX_WIDTH);
        end
        h13 = grid_height_reg;
        if (h13 < MIN_DIM)
        begin
            h13 = MIN_DIM;
        end
        else if (h13 > MAX_HEIGHT)
        begin
            h13 = MAX_HEIGHT;
        end

        wrap_c = H_W'(col_reg) >= w13;
        c0     = wrap_c ? '0 : col_reg;
        r_t    = wrap_c ? H_W'(row_reg) + H_W'(1) : H_W'(row_reg);
        m_t    = rmod_reg;
        if (wrap_c)
        begin
            m_t = (rmod_reg == RM_W'(LINES - 1)) ? '0 : rmod_reg + RM_W'(1);
        end
        if (r_t >= h13)
        begin
            r0 = '0;
            m0 = '0;
        end
        else
        begin
            r0 = r_t[ROW_W-1:0];
            m0 = m_t;
        end

        c_t    = H_W'(c0) + H_W'(1);
        wrap_n = c_t >= w13;
        col_next = wrap_n ? '0 : c_t[COL_W-1:0];
        r_t2   = wrap_n ? H_W'(r0) + H_W'(1) : H_W'(r0);
        m_t2   = m0;
        if (wrap_n)
        begin
            m_t2 = (m0 == RM_W'(LINES - 1)) ? '0 : m0 + RM_W'(1);
        end
        if (r_t2 >= h13)
        begin
            row_next  = '0;
            rmod_next = '0;
        end
        else
        begin
            row_next  = r_t2[ROW_W-1:0];
            rmod_next = m_t2;
        end

        emit0 = (H_W'(r0) >= H_W'(LINES)) && (H_W'(c0) >= H_W'(LINES));
        last0 = (H_W'(r0) == h13 - H_W'(1)) && (H_W'(c0) == w13 - H_W'(1));
        crow0 = r0 - ROW_W'(HALF);
        ccol0 = c0 - COL_W'(HALF);
    end

    // one memory per buffered line; slot rmod takes the new sample after its read
    for (genvar j = 0; j < LINES; j++)
    begin : g_line
        assign ram_we[j] = acc_smp && (m0 == RM_W'(j));

        sds_ram #(
            .WIDTH (SB),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (ram_we[j]),
            .waddr (c0),
            .wdata (in_value),
            .re    (acc_smp),
            .raddr (c0),
            .rdata (ram_rd[j])
        );
    end

    // new window column: oldest line on top, live sample at the bottom
    always_comb
    begin
        for (int k = 0; k < LINES; k++)
        begin
            slot_sum[k] = {1'b0, rm1_reg} + (RM_W + 1)'(k);
            if (slot_sum[k] >= (RM_W + 1)'(LINES))
            begin
                slot_sum[k] = slot_sum[k] - (RM_W + 1)'(LINES);
            end
            col_in[k] = $signed(ram_rd[slot_sum[k][RM_W-1:0]]);
        end
        col_in[MASK_SIZE-1] = val_reg[1];
    end

    always_comb
    begin
        wctrl.shift    = adv && v_reg[1] && smp_reg[1];
        wctrl.load     = adv && v_reg[2] && !smp_reg[2];
        wctrl.mul      = adv && v_reg[2] && smp_reg[2];
        wctrl.step     = adv;
        wctrl.load_idx = idx_reg[2];
    end

    sds_window #(
        .MASK_SIZE   (MASK_SIZE),
        .SAMPLE_BITS (SB)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (wctrl),
        .coef   (val_reg[2]),
        .col_in (col_in),
        .center (center),
        .acc    (acc)
    );

    // Laplacian: round half up at the coefficient point, then saturate
    always_comb
    begin
        acc_rnd = ($signed({acc[ACC_W-1], acc}) + LAP_HALF) >>> COEF_FRAC;
        if (acc_rnd > LAP_MAX)
        begin
            lap_sat = S_MAX;
        end
        else if (acc_rnd < LAP_MIN)
        begin
            lap_sat = S_MIN;
        end
        else
        begin
            lap_sat = acc_rnd[SB-1:0];
        end
    end

    // new value: centre scaled to the gain point plus gain times Laplacian
    always_comb
    begin
        nv_sum = $signed({{(NV_W - SB - GAIN_FRAC){ctr_reg[7][SB-1]}}, ctr_reg[7],
                          {GAIN_FRAC{1'b0}}})
               + $signed({{(NV_W - GP_W){gp_reg[GP_W-1]}}, gp_reg})
               + NV_HALF;
        nv_sh = nv_sum >>> GAIN_FRAC;
        if (nv_sh > NV_MAX)
        begin
            nv_sat = S_MAX;
        end
        else if (nv_sh < NV_MIN)
        begin
            nv_sat = S_MIN;
        end
        else
        begin
            nv_sat = nv_sh[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= WIDTH_RESET;
            grid_height_reg <= HEIGHT_RESET;
            step_gain_reg   <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            rmod_reg        <= '0;
            v_reg           <= '0;
            mvalid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW_W-1:0];
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[H_W-1:0];
                    CFG_STEP_GAIN:   step_gain_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (acc_smp)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                rmod_reg <= rmod_next;
            end
            if (adv)
            begin
                v_reg[1]   <= acc_in;
                v_reg[2]   <= v_reg[1];
                v_reg[3]   <= v_reg[2] && smp_reg[2] && emit_reg[2];
                v_reg[4]   <= v_reg[3];
                v_reg[5]   <= v_reg[4];
                v_reg[6]   <= v_reg[5];
                v_reg[7]   <= v_reg[6];
                mvalid_reg <= v_reg[7];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            smp_reg[1]  <= (s_tuser == ACT_SAMPLE);
            idx_reg[1]  <= in_idx;
            val_reg[1]  <= in_value;
            emit_reg[1] <= emit0;
            rm1_reg     <= m0;
            meta_reg[1] <= '{row: crow0, last: last0};
            colp_reg[1] <= ccol0;

            smp_reg[2]  <= smp_reg[1];
            idx_reg[2]  <= idx_reg[1];
            val_reg[2]  <= val_reg[1];
            emit_reg[2] <= emit_reg[1];

            for (int i = 2; i <= 7; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
                colp_reg[i] <= colp_reg[i-1];
            end

            ctr_reg[3] <= center;
            for (int i = 4; i <= 7; i++)
            begin
                ctr_reg[i] <= ctr_reg[i-1];
            end

            lap6_reg <= lap_sat;
            lap7_reg <= lap6_reg;
            gp_reg   <= $signed({1'b0, step_gain_reg}) * lap6_reg;

            if (v_reg[7])
            begin
                out_nv_reg   <= nv_sat;
                out_lap_reg  <= lap7_reg;
                out_meta_reg <= meta_reg[7];
                out_col_reg  <= colp_reg[7];
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_col_reg, out_meta_reg.row, out_lap_reg, out_nv_reg});
    assign m_tlast  = out_meta_reg.last;

    // an interior sample must reach the product stage
    a_emit_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v_reg[2] && smp_reg[2] && emit_reg[2] |=> v_reg[3])
        else $error("interior sample lost before product stage");

    // line slot tracks the row: row zero always uses slot zero
    a_slot_row0: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg == '0 |-> rmod_reg == '0)
        else $error("line slot out of step with row counter");

    a_one_line_written: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ram_we))
        else $error("more than one line memory written");

    a_load_vs_mul: assert property (@(posedge clk) disable iff (!rst_n)
        !(wctrl.load && wctrl.mul))
        else $error("coefficient load and product step in one cycle");

    // reported cells are interior
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        mvalid_reg |-> (out_meta_reg.row >= ROW_W'(HALF)) && (out_col_reg >= COL_W'(HALF)))
        else $error("border cell reported");

endmodule

`default_nettype wire

// ===== rtl/sds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sds_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/sds_cell.sv =====
// One window cell: a sample register, its mask coefficient and their product.
// Depends on sds_pkg.
`default_nettype none

module sds_cell #(
    parameter int SAMPLE_BITS = 18,
    parameter int TAP         = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sds_pkg::cell_ctrl_t             ctrl,
    input  logic signed [SAMPLE_BITS-1:0]   coef,
    input  logic signed [SAMPLE_BITS-1:0]   din,
    output logic signed [SAMPLE_BITS-1:0]   smp,
    output logic signed [2*SAMPLE_BITS-1:0] prod
);

    import sds_pkg::*;

    // taps beyond the reach of the index field are never loaded
    localparam bit TAP_OK = TAP < (1 << IDX_W);

    logic signed [SAMPLE_BITS-1:0]   smp_reg;
    logic signed [SAMPLE_BITS-1:0]   coef_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic                            hit;

    assign hit = TAP_OK && ctrl.load && (ctrl.load_idx == IDX_W'(TAP));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_reg  <= '0;
            coef_reg <= '0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                smp_reg <= din;
            end
            if (hit)
            begin
                coef_reg <= coef;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= coef_reg * smp_reg;
        end
    end

    assign smp  = smp_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/sds_window.sv =====
// Square window of cells, each row a shift chain fed at its right end,
// followed by registered row sums and the registered total.
// Depends on sds_pkg and sds_cell.
`default_nettype none

module sds_window #(
    parameter int MASK_SIZE   = 3,
    parameter int SAMPLE_BITS = 18,
    localparam int ACC_W      = 2 * SAMPLE_BITS + 2 * $clog2(MASK_SIZE)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sds_pkg::cell_ctrl_t           ctrl,
    input  logic signed [SAMPLE_BITS-1:0] coef,
    input  logic signed [SAMPLE_BITS-1:0] col_in [MASK_SIZE],
    output logic signed [SAMPLE_BITS-1:0] center,
    output logic signed [ACC_W-1:0]       acc
);

    import sds_pkg::*;

    localparam int HALF = MASK_SIZE / 2;
    localparam int RS_W = 2 * SAMPLE_BITS + $clog2(MASK_SIZE);

    logic signed [SAMPLE_BITS-1:0]   smp  [MASK_SIZE][MASK_SIZE];
    logic signed [SAMPLE_BITS-1:0]   din  [MASK_SIZE][MASK_SIZE];
    logic signed [2*SAMPLE_BITS-1:0] prod [MASK_SIZE][MASK_SIZE];
    logic signed [RS_W-1:0]          rsum_next [MASK_SIZE];
    logic signed [RS_W-1:0]          rsum_reg  [MASK_SIZE];
    logic signed [ACC_W-1:0]         acc_next;
    logic signed [ACC_W-1:0]         acc_reg;

    for (genvar r = 0; r < MASK_SIZE; r++)
    begin : g_row
        for (genvar c = 0; c < MASK_SIZE; c++)
        begin : g_col
            if (c == MASK_SIZE - 1)
            begin : g_edge
                assign din[r][c] = col_in[r];
            end
            else
            begin : g_inner
                assign din[r][c] = smp[r][c+1];
            end

            sds_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .TAP         (r * MASK_SIZE + c)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .coef  (coef),
                .din   (din[r][c]),
                .smp   (smp[r][c]),
                .prod  (prod[r][c])
            );
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int r = 0; r < MASK_SIZE; r++)
        begin
            rsum_next[r] = '0;
            for (int c = 0; c < MASK_SIZE; c++)
            begin
                rsum_next[r] = rsum_next[r] + RS_W'(prod[r][c]);
            end
            acc_next = acc_next + ACC_W'(rsum_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            for (int r = 0; r < MASK_SIZE; r++)
            begin
                rsum_reg[r] <= rsum_next[r];
            end
            acc_reg <= acc_next;
        end
    end

    assign center = smp[HALF][HALF];
    assign acc    = acc_reg;

endmodule

`default_nettype wire
